// File: rtl/core/mstp_pkg.sv
// ----------------------------------------------------------------------------
// mstp_pkg
// Shared types, constants and CRC functions for the MS/TP frame receiver.
// ----------------------------------------------------------------------------
package mstp_pkg;

    // Largest payload accepted after a good header
    localparam logic [15:0] MAX_PAYLOAD = 16'd512;

    localparam logic [7:0] PREAMBLE_1 = 8'h55;
    localparam logic [7:0] PREAMBLE_2 = 8'hFF;
    localparam logic [7:0] HDR_CRC_INIT = 8'hFF;
    localparam logic [15:0] DATA_CRC_INIT = 16'hFFFF;
    localparam logic [2:0] HDR_CRC_IDX = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PRE    = 3'd1,
        PH_HEADER = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRC_L  = 3'd4,
        PH_CRC_H  = 3'd5
    } rx_phase_t;

    typedef enum logic [2:0] {
        EV_HDR_NO_DATA  = 3'd0,
        EV_HDR_DATA     = 3'd1,
        EV_LEN_OVER     = 3'd2,
        EV_HDR_CRC_ERR  = 3'd3,
        EV_PAYLOAD      = 3'd4,
        EV_FRAME_OK     = 3'd5,
        EV_DATA_CRC_ERR = 3'd6
    } event_t;

    // One result beat
    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  frame_type;
        logic [7:0]  dest_addr;
        logic [7:0]  src_addr;
        logic [15:0] data_length;
        logic [7:0]  payload_byte;
        logic        for_me;
        logic [31:0] good_header_count;
        logic [31:0] crc_error_count;
    } res_t;

    // Header CRC-8 update for one byte
    function automatic logic [7:0] hdr_crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0]  c;
        logic [15:0] w;
        c = crc ^ b;
        w = 16'h0000;
        for (int i = 0; i < 8; i++) begin
            w = w ^ ({8'h00, c} << i);
        end
        return (w[7:0] & 8'hFE) ^ {7'h00, w[8]};
    endfunction

    // Data CRC-16 update for one byte
    function automatic logic [15:0] data_crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] lo;
        lo = crc[7:0] ^ b;
        return {8'h00, crc[15:8]} ^ {lo, 8'h00} ^ {5'h00, lo, 3'h0}
             ^ {lo[3:0], 12'h000} ^ {12'h000, lo[7:4]} ^ {12'h000, lo[3:0]}
             ^ {5'h00, lo[3:0], 7'h00};
    endfunction

endpackage

// File: rtl/core/mstp_rx_fsm.sv
// ----------------------------------------------------------------------------
// mstp_rx_fsm
// Frame state machine: preamble hunt, header capture and CRC-8, payload
// streaming with CRC-16, counters. Produces at most one result per beat.
// ----------------------------------------------------------------------------
module mstp_rx_fsm
    import mstp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_accept,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    output res_t        res
);

    rx_phase_t   phase_reg, phase_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  hdr_crc_reg, hdr_crc_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  dest_reg, dest_next;
    logic [7:0]  src_reg, src_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] pay_idx_reg, pay_idx_next;
    logic [15:0] data_crc_reg, data_crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [31:0] hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] err_cnt_reg, err_cnt_next;
    logic [7:0]  own_addr_reg;

    logic        hdr_crc_ok;
    logic        data_crc_ok;
    logic        len_zero;
    logic        len_ok;
    logic [15:0] pay_idx_inc;

    assign hdr_crc_ok  = (~hdr_crc_reg) == rx_byte;
    assign data_crc_ok = (~data_crc_reg) == {rx_byte, crc_low_reg};
    assign len_zero    = length_reg == 16'h0000;
    assign len_ok      = length_reg <= MAX_PAYLOAD;
    assign pay_idx_inc = pay_idx_reg + 16'd1;

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (rx_byte == PREAMBLE_1) phase_next = PH_PRE;
            end
            PH_PRE: begin
                if (rx_byte == PREAMBLE_2) phase_next = PH_HEADER;
                else if (rx_byte != PREAMBLE_1) phase_next = PH_IDLE;
            end
            PH_HEADER: begin
                if (hdr_idx_reg >= HDR_CRC_IDX) begin
                    if (hdr_crc_ok && !len_zero && len_ok) phase_next = PH_DATA;
                    else phase_next = PH_IDLE;
                end
            end
            PH_DATA: begin
                if (pay_idx_inc >= length_reg) phase_next = PH_CRC_L;
            end
            PH_CRC_L: phase_next = PH_CRC_H;
            PH_CRC_H: phase_next = PH_IDLE;
            default:  phase_next = PH_IDLE;
        endcase
    end

    // Datapath updates and result
    always_comb begin
        hdr_idx_next  = hdr_idx_reg;
        hdr_crc_next  = hdr_crc_reg;
        type_next     = type_reg;
        dest_next     = dest_reg;
        src_next      = src_reg;
        length_next   = length_reg;
        pay_idx_next  = pay_idx_reg;
        data_crc_next = data_crc_reg;
        crc_low_next  = crc_low_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        err_cnt_next  = err_cnt_reg;
        res_valid     = 1'b0;
        res.event_res = EV_HDR_NO_DATA;
        res.payload_byte = 8'h00;

        unique case (phase_reg)
            PH_IDLE: ;
            PH_PRE: begin
                if (rx_byte == PREAMBLE_2) begin
                    hdr_idx_next = 3'd0;
                    hdr_crc_next = HDR_CRC_INIT;
                end
            end
            PH_HEADER: begin
                if (hdr_idx_reg < HDR_CRC_IDX) begin
                    case (hdr_idx_reg)
                        3'd0:    type_next = rx_byte;
                        3'd1:    dest_next = rx_byte;
                        3'd2:    src_next = rx_byte;
                        3'd3:    length_next = {rx_byte, length_reg[7:0]};
                        default: length_next = {length_reg[15:8], rx_byte};
                    endcase
                    hdr_crc_next = hdr_crc_step(hdr_crc_reg, rx_byte);
                    hdr_idx_next = hdr_idx_reg + 3'd1;
                end else begin
                    hdr_idx_next = 3'd0;
                    res_valid    = 1'b1;
                    if (!hdr_crc_ok) begin
                        err_cnt_next  = err_cnt_reg + 32'd1;
                        res.event_res = EV_HDR_CRC_ERR;
                    end else begin
                        hdr_cnt_next = hdr_cnt_reg + 32'd1;
                        if (len_zero) begin
                            res.event_res = EV_HDR_NO_DATA;
                        end else if (len_ok) begin
                            pay_idx_next  = 16'h0000;
                            data_crc_next = DATA_CRC_INIT;
                            res.event_res = EV_HDR_DATA;
                        end else begin
                            res.event_res = EV_LEN_OVER;
                        end
                    end
                end
            end
            PH_DATA: begin
                data_crc_next    = data_crc_step(data_crc_reg, rx_byte);
                pay_idx_next     = pay_idx_inc;
                res_valid        = 1'b1;
                res.event_res    = EV_PAYLOAD;
                res.payload_byte = rx_byte;
            end
            PH_CRC_L: crc_low_next = rx_byte;
            PH_CRC_H: begin
                res_valid = 1'b1;
                if (data_crc_ok) begin
                    res.event_res = EV_FRAME_OK;
                end else begin
                    err_cnt_next  = err_cnt_reg + 32'd1;
                    res.event_res = EV_DATA_CRC_ERR;
                end
            end
            default: ;
        endcase

        res.frame_type        = type_reg;
        res.dest_addr         = dest_reg;
        res.src_addr          = src_reg;
        res.data_length       = length_reg;
        res.for_me            = dest_reg == own_addr_reg;
        res.good_header_count = hdr_cnt_next;
        res.crc_error_count   = err_cnt_next;
    end

    // Own station address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg <= 8'h00;
        end else if (cfg_wr_en) begin
            own_addr_reg <= cfg_wr_data;
        end
    end

    // Advance state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            hdr_idx_reg  <= 3'd0;
            hdr_crc_reg  <= HDR_CRC_INIT;
            type_reg     <= 8'h00;
            dest_reg     <= 8'h00;
            src_reg      <= 8'h00;
            length_reg   <= 16'h0000;
            pay_idx_reg  <= 16'h0000;
            data_crc_reg <= DATA_CRC_INIT;
            crc_low_reg  <= 8'h00;
            hdr_cnt_reg  <= 32'd0;
            err_cnt_reg  <= 32'd0;
        end else if (in_accept) begin
            phase_reg    <= phase_next;
            hdr_idx_reg  <= hdr_idx_next;
            hdr_crc_reg  <= hdr_crc_next;
            type_reg     <= type_next;
            dest_reg     <= dest_next;
            src_reg      <= src_next;
            length_reg   <= length_next;
            pay_idx_reg  <= pay_idx_next;
            data_crc_reg <= data_crc_next;
            crc_low_reg  <= crc_low_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            err_cnt_reg  <= err_cnt_next;
        end
    end

endmodule

// File: rtl/core/mstp_out_reg.sv
// ----------------------------------------------------------------------------
// mstp_out_reg
// Result output register with a skid stage, so the input side keeps taking
// beats while a result waits on the output.
// ----------------------------------------------------------------------------
module mstp_out_reg
    import mstp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  res_t push_res,
    output logic in_ready,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_res
);

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;
    logic pop;

    assign pop      = main_valid_reg && m_ready;
    assign in_ready = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_res    = main_reg;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) skid_valid_reg <= 1'b0;
        end else if (push) begin
            if (main_valid_reg && !pop) skid_valid_reg <= 1'b1;
            else main_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload: refill main from skid, else hold or load the new result
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) main_reg <= skid_reg;
        end else if (push) begin
            if (main_valid_reg && !pop) skid_reg <= push_res;
            else main_reg <= push_res;
        end
    end

endmodule

// File: rtl/core/mstp_frame_receiver.sv
// ----------------------------------------------------------------------------
// mstp_frame_receiver
// A result is registered into the output stage as its byte is accepted.
// Throughput: one byte per cycle while s_ready is high; the per-byte CRC
// and phase update sit between the input handshake and the result register.
// s_ready drops only while both output register and skid stage are full.
// Reset (aresetn low, synchronous) returns to preamble hunt, clears counters,
// header fields and own_address, and empties the output stage.
// ----------------------------------------------------------------------------
module mstp_frame_receiver
    import mstp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [7:0]  m_frame_type,
    output logic [7:0]  m_dest_addr,
    output logic [7:0]  m_src_addr,
    output logic [15:0] m_data_length,
    output logic [7:0]  m_payload_byte,
    output logic        m_for_me,
    output logic [31:0] m_good_header_count,
    output logic [31:0] m_crc_error_count
);

    logic in_accept;
    logic res_valid;
    res_t res;
    res_t out_res;

    assign in_accept = s_valid && s_ready;

    mstp_rx_fsm u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (in_accept),
        .rx_byte     (s_rx_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    mstp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (in_accept && res_valid),
        .push_res (res),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (out_res)
    );

    assign m_event_res         = out_res.event_res;
    assign m_frame_type        = out_res.frame_type;
    assign m_dest_addr         = out_res.dest_addr;
    assign m_src_addr          = out_res.src_addr;
    assign m_data_length       = out_res.data_length;
    assign m_payload_byte      = out_res.payload_byte;
    assign m_for_me            = out_res.for_me;
    assign m_good_header_count = out_res.good_header_count;
    assign m_crc_error_count   = out_res.crc_error_count;

endmodule

// File: rtl/core/mstp_frame_receiver_checker.sv
// ----------------------------------------------------------------------------
// mstp_frame_receiver_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mstp_frame_receiver_checker
    import mstp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_event_res,
    input logic [15:0] m_data_length,
    input logic [7:0]  m_payload_byte,
    input logic [31:0] m_crc_error_count
);

    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res) && $stable(m_payload_byte)
                                && $stable(m_crc_error_count))
        else $error("stalled result changed");

    // Payload byte is zero outside payload events
    a_pay_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res != EV_PAYLOAD) |-> m_payload_byte == 8'h00)
        else $error("payload byte set on non-payload event");

    // Header events agree with the length field
    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_HDR_NO_DATA) |-> m_data_length == 16'h0000)
        else $error("no-data header with nonzero length");

    a_len_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_HDR_DATA)
        |-> (m_data_length != 16'h0000) && (m_data_length <= MAX_PAYLOAD))
        else $error("data header with length out of range");

    a_len_over: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_LEN_OVER) |-> m_data_length > MAX_PAYLOAD)
        else $error("over-limit event with length in range");

endmodule

bind mstp_frame_receiver mstp_frame_receiver_checker u_mstp_chk (.*);

// File: verif/mstp_frame_checker.sv
// ----------------------------------------------------------------------------
// mstp_frame_checker
// Watches the byte input and the event output of the MS/TP frame receiver.
// Tracks the receive phase, header CRC-8 and data CRC-16 on its own, queues
// the event each accepted byte should raise, and compares every event beat
// with the oldest queued one. Mismatch and backlog counts go to the top.
// ----------------------------------------------------------------------------
module mstp_frame_checker
    import mstp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [2:0]         m_event_res,
    input  logic [7:0]         m_frame_type,
    input  logic [7:0]         m_dest_addr,
    input  logic [7:0]         m_src_addr,
    input  logic [15:0]        m_data_length,
    input  logic [7:0]         m_payload_byte,
    input  logic               m_for_me,
    input  logic [31:0]        m_good_header_count,
    input  logic [31:0]        m_crc_error_count,
    output int unsigned        mismatch_total,
    output int unsigned        pending_total,
    output int unsigned        checked_total,
    output logic [6:0]         events_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow receiver state
    rx_phase_t   phase;
    logic [2:0]  hdr_pos;
    logic [7:0]  hdr_crc;
    logic [7:0]  hdr_type;
    logic [7:0]  hdr_dest;
    logic [7:0]  hdr_src;
    logic [15:0] hdr_len;
    logic [15:0] payload_cnt;
    logic [15:0] data_crc;
    logic [7:0]  data_crc_lo;
    logic [31:0] good_headers;
    logic [31:0] crc_failures;
    logic [7:0]  station_addr;

    res_t        expected_events[$];
    int unsigned mismatches;
    int unsigned checked;
    logic [6:0]  event_mask;

    // Header CRC-8: bit k of the folded value is the parity of c[k:0],
    // bit 0 takes the parity of c[7:1] (the carry out of the fold)
    function automatic logic [7:0] hdr_crc_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] r;
        logic       par;
        c   = crc ^ b;
        par = 1'b0;
        for (int k = 0; k < 8; k++) begin
            par  = par ^ c[k];
            r[k] = par;
        end
        r[0] = ^c[7:1];
        return r;
    endfunction

    // Data CRC-16, one byte, reflected form
    function automatic logic [15:0] data_crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] x;
        x = {8'h00, crc[7:0] ^ b};
        return (crc >> 8) ^ (x << 8) ^ (x << 3) ^ (x << 12) ^ (x >> 4)
             ^ (x & 16'h000F) ^ ((x & 16'h000F) << 7);
    endfunction

    function automatic res_t make_event(input event_t ev, input logic [7:0] pb);
        res_t r;
        r.event_res         = ev;
        r.frame_type        = hdr_type;
        r.dest_addr         = hdr_dest;
        r.src_addr          = hdr_src;
        r.data_length       = hdr_len;
        r.payload_byte      = pb;
        r.for_me            = (hdr_dest == station_addr);
        r.good_header_count = good_headers;
        r.crc_error_count   = crc_failures;
        return r;
    endfunction

    function automatic string describe(input res_t r);
        return $sformatf({"ev=%0d type=%02h dest=%02h src=%02h len=%04h byte=%02h",
                          " me=%0b good=%0d err=%0d"},
                         r.event_res, r.frame_type, r.dest_addr, r.src_addr, r.data_length,
                         r.payload_byte, r.for_me, r.good_header_count, r.crc_error_count);
    endfunction

    // Advance the shadow receiver by one byte and queue what it should report
    task automatic predict_byte(input logic [7:0] b);
        case (phase)
            PH_IDLE: begin
                if (b == PREAMBLE_1) phase = PH_PRE;
            end
            PH_PRE: begin
                if (b == PREAMBLE_2) begin
                    phase   = PH_HEADER;
                    hdr_pos = '0;
                    hdr_crc = HDR_CRC_INIT;
                end else if (b != PREAMBLE_1) begin
                    phase = PH_IDLE;
                end
            end
            PH_HEADER: begin
                if (hdr_pos < HDR_CRC_IDX) begin
                    case (hdr_pos)
                        3'd0: hdr_type = b;
                        3'd1: hdr_dest = b;
                        3'd2: hdr_src = b;
                        3'd3: hdr_len[15:8] = b;
                        default: hdr_len[7:0] = b;
                    endcase
                    hdr_crc = hdr_crc_next(hdr_crc, b);
                    hdr_pos = hdr_pos + 3'd1;
                end else begin
                    hdr_pos = '0;
                    phase   = PH_IDLE;
                    if (~hdr_crc != b) begin
                        crc_failures = crc_failures + 32'd1;
                        expected_events = {expected_events, make_event(EV_HDR_CRC_ERR, 8'h00)};
                    end else begin
                        good_headers = good_headers + 32'd1;
                        if (hdr_len == 16'h0000) begin
                            expected_events = {expected_events,
                                               make_event(EV_HDR_NO_DATA, 8'h00)};
                        end else if (hdr_len <= MAX_PAYLOAD) begin
                            phase       = PH_DATA;
                            payload_cnt = '0;
                            data_crc    = DATA_CRC_INIT;
                            expected_events = {expected_events,
                                               make_event(EV_HDR_DATA, 8'h00)};
                        end else begin
                            expected_events = {expected_events,
                                               make_event(EV_LEN_OVER, 8'h00)};
                        end
                    end
                end
            end
            PH_DATA: begin
                data_crc    = data_crc_next(data_crc, b);
                payload_cnt = payload_cnt + 16'd1;
                if (payload_cnt >= hdr_len) phase = PH_CRC_L;
                expected_events = {expected_events, make_event(EV_PAYLOAD, b)};
            end
            PH_CRC_L: begin
                data_crc_lo = b;
                phase       = PH_CRC_H;
            end
            PH_CRC_H: begin
                phase = PH_IDLE;
                if (~data_crc == {b, data_crc_lo}) begin
                    expected_events = {expected_events, make_event(EV_FRAME_OK, 8'h00)};
                end else begin
                    crc_failures = crc_failures + 32'd1;
                    expected_events = {expected_events, make_event(EV_DATA_CRC_ERR, 8'h00)};
                end
            end
            default: phase = PH_IDLE;
        endcase
    endtask

    // Compare the output beat first: it can only belong to an older byte
    always @(posedge aclk) begin
        res_t seen;
        res_t want;
        if (!aresetn) begin
            phase        = PH_IDLE;
            hdr_pos      = '0;
            hdr_crc      = HDR_CRC_INIT;
            hdr_type     = '0;
            hdr_dest     = '0;
            hdr_src      = '0;
            hdr_len      = '0;
            payload_cnt  = '0;
            data_crc     = DATA_CRC_INIT;
            data_crc_lo  = '0;
            good_headers = '0;
            crc_failures = '0;
            station_addr = '0;
            mismatches   = 0;
            checked      = 0;
            event_mask   = '0;
            expected_events.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen.event_res         = m_event_res;
                seen.frame_type        = m_frame_type;
                seen.dest_addr         = m_dest_addr;
                seen.src_addr          = m_src_addr;
                seen.data_length       = m_data_length;
                seen.payload_byte      = m_payload_byte;
                seen.for_me            = m_for_me;
                seen.good_header_count = m_good_header_count;
                seen.crc_error_count   = m_crc_error_count;
                checked++;
                if (m_event_res <= EV_DATA_CRC_ERR) event_mask[m_event_res] = 1'b1;
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("event beat %0d with nothing expected: %s",
                                 checked, describe(seen));
                end else begin
                    want = expected_events.pop_front();
                    if (seen.event_res !== want.event_res
                        || seen.frame_type !== want.frame_type
                        || seen.dest_addr !== want.dest_addr
                        || seen.src_addr !== want.src_addr
                        || seen.data_length !== want.data_length
                        || seen.payload_byte !== want.payload_byte
                        || seen.for_me !== want.for_me
                        || seen.good_header_count !== want.good_header_count
                        || seen.crc_error_count !== want.crc_error_count) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("event beat %0d mismatch at %0t", checked, $realtime);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(seen));
                        end
                    end
                end
            end
            if (s_valid && s_ready) predict_byte(s_rx_byte);
            if (cfg_wr_en) station_addr = cfg_wr_data;
        end
        mismatch_total <= mismatches;
        pending_total  <= expected_events.size();
        checked_total  <= checked;
        events_seen    <= event_mask;
    end

endmodule

// File: verif/mstp_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// mstp_frame_receiver_tb
// Feeds the MS/TP frame receiver with serial bytes: a few hand-built frames
// for every event kind, then random well-formed frames mixed with corrupted,
// truncated and noise traffic, under several station addresses. The sender
// works in bursts, the receiver stalls on changing patterns and once holds
// off long enough to back up the input. The checker module does the scoring.
// ----------------------------------------------------------------------------
module mstp_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mstp_pkg::*;

    localparam int unsigned CLK_HALF    = 10;
    localparam int unsigned N_ITEMS     = 1800;
    localparam int unsigned N_PHASES    = 6;
    localparam int unsigned HOLD_CYCLES = 250;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum int {
        RDY_ALWAYS,
        RDY_PATTERN,
        RDY_RANDOM
    } ready_mode_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_valid     = 1'b0;
    logic [7:0]  s_rx_byte   = 8'h00;
    logic        m_ready     = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_event_res;
    logic [7:0]  m_frame_type;
    logic [7:0]  m_dest_addr;
    logic [7:0]  m_src_addr;
    logic [15:0] m_data_length;
    logic [7:0]  m_payload_byte;
    logic        m_for_me;
    logic [31:0] m_good_header_count;
    logic [31:0] m_crc_error_count;

    int unsigned mismatch_total;
    int unsigned pending_total;
    int unsigned checked_total;
    logic [6:0]  events_seen;

    // Stimulus bookkeeping
    logic [7:0]  tx_bytes[$];
    int unsigned bytes_sent    = 0;
    int unsigned burst_left    = 0;
    bit          gaps_on       = 1'b1;
    int unsigned addr_settings = 0;
    int unsigned hold_asks     = 0;
    int unsigned cycle_count   = 0;
    ready_mode_t ready_mode    = RDY_ALWAYS;
    logic [15:0] ready_pattern = 16'hFFFF;
    int unsigned ready_pct     = 100;

    always #(CLK_HALF) aclk = ~aclk;

    mstp_frame_receiver dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_rx_byte           (s_rx_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_event_res         (m_event_res),
        .m_frame_type        (m_frame_type),
        .m_dest_addr         (m_dest_addr),
        .m_src_addr          (m_src_addr),
        .m_data_length       (m_data_length),
        .m_payload_byte      (m_payload_byte),
        .m_for_me            (m_for_me),
        .m_good_header_count (m_good_header_count),
        .m_crc_error_count   (m_crc_error_count)
    );

    mstp_frame_checker chk (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_rx_byte           (s_rx_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_event_res         (m_event_res),
        .m_frame_type        (m_frame_type),
        .m_dest_addr         (m_dest_addr),
        .m_src_addr          (m_src_addr),
        .m_data_length       (m_data_length),
        .m_payload_byte      (m_payload_byte),
        .m_for_me            (m_for_me),
        .m_good_header_count (m_good_header_count),
        .m_crc_error_count   (m_crc_error_count),
        .mismatch_total      (mismatch_total),
        .pending_total       (pending_total),
        .checked_total       (checked_total),
        .events_seen         (events_seen)
    );

    // Offer one byte; open a gap first when the current burst is used up
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 12) : 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_bytes();
        foreach (tx_bytes[i]) push_byte(tx_bytes[i]);
        tx_bytes.delete();
    endtask

    // Append a complete frame with correct CRCs; payload only when in range
    task automatic compose_frame(input logic [7:0] ftype, input logic [7:0] dest,
                                 input logic [7:0] src, input logic [15:0] len);
        logic [7:0]  hdr[5];
        logic [7:0]  hcrc;
        logic [7:0]  pb;
        logic [15:0] dcrc;
        hdr = '{ftype, dest, src, len[15:8], len[7:0]};
        repeat ($urandom_range(1, 3)) tx_bytes = {tx_bytes, PREAMBLE_1};
        tx_bytes = {tx_bytes, PREAMBLE_2};
        hcrc = HDR_CRC_INIT;
        foreach (hdr[i]) begin
            tx_bytes = {tx_bytes, hdr[i]};
            hcrc = hdr_crc_step(hcrc, hdr[i]);
        end
        tx_bytes = {tx_bytes, ~hcrc};
        if (len != 16'h0000 && len <= MAX_PAYLOAD) begin
            dcrc = DATA_CRC_INIT;
            repeat (len) begin
                pb = 8'($urandom);
                tx_bytes = {tx_bytes, pb};
                dcrc = data_crc_step(dcrc, pb);
            end
            tx_bytes = {tx_bytes, ~dcrc[7:0]};
            tx_bytes = {tx_bytes, ~dcrc[15:8]};
        end
    endtask

    // Drain all pending events, let the last silent byte settle, then write
    task automatic set_station(input logic [7:0] addr);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_total != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        addr_settings++;
    endtask

    // Mostly clean frames, mixed with bit errors, cut-off frames and line noise
    task automatic random_traffic(input int unsigned budget, input logic [7:0] station);
        int unsigned used;
        int unsigned pick;
        int unsigned kind;
        int unsigned idx;
        int unsigned cut;
        logic [7:0]  dest;
        logic [15:0] len;
        used = 0;
        while (used < budget) begin
            pick = $urandom_range(0, 99);
            if (pick >= 85) begin
                // Noise, weighted toward the sync byte to provoke false starts
                repeat ($urandom_range(1, 6))
                    tx_bytes = {tx_bytes,
                                ($urandom_range(0, 1) == 0) ? PREAMBLE_1 : 8'($urandom)};
                used += tx_bytes.size();
                send_bytes();
            end else begin
                case ($urandom_range(0, 3))
                    0: dest = station;
                    1: dest = 8'hFF;
                    default: dest = 8'($urandom);
                endcase
                kind = $urandom_range(0, 99);
                if (kind < 10) begin
                    len = 16'h0000;
                end else if (kind < 16) begin
                    case ($urandom_range(0, 2))
                        0: len = 16'hFFFF;
                        1: len = MAX_PAYLOAD + 16'd1;
                        default: len = 16'($urandom_range(int'(MAX_PAYLOAD) + 1, 65535));
                    endcase
                end else if (kind < 18) begin
                    len = 16'($urandom_range(int'(MAX_PAYLOAD) - 12, int'(MAX_PAYLOAD)));
                end else begin
                    len = 16'($urandom_range(1, 12));
                end
                compose_frame(8'($urandom), dest, 8'($urandom), len);
                if (pick >= 60 && pick < 75) begin
                    // Flip one bit past the sync pair
                    idx = $urandom_range(2, tx_bytes.size() - 1);
                    tx_bytes[idx] = tx_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
                end else if (pick >= 75) begin
                    // Cut the frame short; the next bytes land mid-frame
                    cut = $urandom_range(1, tx_bytes.size() - 1);
                    while (tx_bytes.size() > cut) void'(tx_bytes.pop_back());
                end
                used += tx_bytes.size();
                send_bytes();
            end
        end
    endtask

    // Output side: stall pattern per phase, plus requested long hold-offs
    initial begin
        int unsigned hold_left;
        int unsigned holds_done;
        int unsigned step;
        hold_left  = 0;
        holds_done = 0;
        step       = 0;
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && holds_done != hold_asks) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    RDY_ALWAYS:  m_ready <= 1'b1;
                    RDY_PATTERN: m_ready <= ready_pattern[step % 16];
                    default:     m_ready <= ($urandom_range(0, 99) < ready_pct);
                endcase
            end
            step++;
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("watchdog expired after %0d cycles, %0d events outstanding",
                 cycle_count, pending_total);
        $display("mstp_frame_receiver_tb: done, errors");
        $finish;
    end

    initial begin
        logic [7:0]  station;
        int unsigned target;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        set_station(8'h00);

        // Directed: false start then a zero-length header addressed to us
        tx_bytes = '{8'h00, PREAMBLE_1, 8'h12};
        compose_frame(8'hFF, 8'h00, 8'hFF, 16'h0000);
        // Largest length field, and one just past the limit
        compose_frame(8'h00, 8'hFF, 8'h00, 16'hFFFF);
        compose_frame(8'h01, 8'h7F, 8'h80, MAX_PAYLOAD + 16'd1);
        send_bytes();
        // Header CRC broken
        compose_frame(8'h02, 8'h00, 8'h01, 16'h0001);
        tx_bytes[tx_bytes.size() - 4] = ~tx_bytes[tx_bytes.size() - 4];
        send_bytes();
        // Repeated sync byte, one-byte frame that checks out
        tx_bytes = {tx_bytes, PREAMBLE_1};
        compose_frame(8'h03, 8'h00, 8'h05, 16'h0001);
        // Two-byte frame with its data CRC high byte broken
        compose_frame(8'h04, 8'h05, 8'h06, 16'h0002);
        tx_bytes[tx_bytes.size() - 1] = ~tx_bytes[tx_bytes.size() - 1];
        send_bytes();

        // Random phases, each under its own station address and idling style
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: station = 8'hFF;
                N_PHASES - 1: station = 8'h00;
                default: station = 8'($urandom);
            endcase
            set_station(station);
            gaps_on       = (ph != 1);
            ready_mode    = ready_mode_t'(ph % 3);
            ready_pattern = 16'($urandom) | 16'h0001;
            ready_pct     = $urandom_range(30, 90);
            if (ph == 2) begin
                // Long output hold-off while a full-size frame streams in
                hold_asks++;
                compose_frame(8'($urandom), station, 8'($urandom), MAX_PAYLOAD);
                send_bytes();
            end
            // Keep the running byte total on track for the overall budget
            target = (N_ITEMS * (ph + 1)) / N_PHASES;
            if (bytes_sent < target) random_traffic(target - bytes_sent, station);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_total != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("sent %0d bytes under %0d station addresses, checked %0d event beats",
                 bytes_sent, addr_settings, checked_total);
        $display("event codes observed (one bit per code, code 0 rightmost): %b",
                 events_seen);
        if (mismatch_total == 0 && pending_total == 0) begin
            $display("mstp_frame_receiver_tb: done, clean");
        end else begin
            $display("%0d mismatching event beats", mismatch_total);
            $display("mstp_frame_receiver_tb: done, errors");
        end
        $finish;
    end

endmodule
